// ----- sv/ire_pkg.sv -----
// ----------------------------------------------------------------------------
// ire_pkg
// Shared types, protocol codes, status codes and timing tables of the IR
// remote frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ire_pkg;

  typedef logic [3:0]  func_t;
  typedef logic [15:0] addr_t;
  typedef logic [7:0]  cmd_t;
  typedef logic [15:0] us_t;
  typedef logic [10:0] cap_t;
  typedef logic [6:0]  cnt_t;
  typedef logic [1:0]  status_t;

  // protocol codes
  localparam func_t FN_RAW     = 4'd0;
  localparam func_t FN_NEC     = 4'd1;
  localparam func_t FN_NECEXT  = 4'd2;
  localparam func_t FN_SAMSUNG = 4'd3;
  localparam func_t FN_SONY12  = 4'd4;
  localparam func_t FN_SONY15  = 4'd5;
  localparam func_t FN_SONY20  = 4'd6;
  localparam func_t FN_RC5     = 4'd7;
  localparam func_t FN_JVC     = 4'd8;

  // result status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_UNKNOWN  = 2'd1;
  localparam status_t ST_OVERFLOW = 2'd2;

  localparam cap_t CAP_RESET = 11'd128;

  localparam us_t CARRIER_SONY = 16'd40000;
  localparam us_t CARRIER_RC5  = 16'd36000;
  localparam us_t CARRIER_STD  = 16'd38000;

  localparam us_t RC5_SHORT = 16'd889;
  localparam us_t RC5_LONG  = 16'd1778;

  typedef struct packed {
    us_t hdr_mark;
    us_t hdr_space;
    us_t mark0;
    us_t mark1;
    us_t space0;
    us_t space1;
  } timing_t;

  typedef struct packed {
    func_t func;
    addr_t addr;
    cmd_t  cmd;
  } req_t;

  typedef struct packed {
    logic load;
    logic step;
  } gen_ctl_t;

  typedef struct packed {
    us_t  dur;
    logic empty;
  } gen_sts_t;

  typedef struct packed {
    status_t status;
    us_t     mark_us;
    us_t     space_us;
    us_t     carrier_freq;
    cnt_t    duration_count;
    logic    last;
  } result_t;

  function automatic logic is_sony(func_t f);
    return (f == FN_SONY12) || (f == FN_SONY15) || (f == FN_SONY20);
  endfunction

  function automatic us_t carrier_of(func_t f);
    us_t c;
    if (is_sony(f)) begin
      c = CARRIER_SONY;
    end else if (f == FN_RC5) begin
      c = CARRIER_RC5;
    end else begin
      c = CARRIER_STD;
    end
    return c;
  endfunction

  // header and per-bit durations; mark picks by bit for Sony, space otherwise
  function automatic timing_t timing_of(func_t f);
    timing_t t;
    unique case (f)
      FN_NEC, FN_NECEXT: t = '{16'd9000, 16'd4500, 16'd560, 16'd560, 16'd560, 16'd1690};
      FN_SAMSUNG:        t = '{16'd4500, 16'd4500, 16'd560, 16'd560, 16'd560, 16'd1690};
      FN_SONY12, FN_SONY15, FN_SONY20:
                         t = '{16'd2400, 16'd600, 16'd600, 16'd1200, 16'd600, 16'd600};
      FN_JVC:            t = '{16'd8400, 16'd4200, 16'd525, 16'd525, 16'd525, 16'd1575};
      default:           t = '0;
    endcase
    return t;
  endfunction

  // durations of a full frame before a trailing space is dropped
  function automatic cnt_t ndur_of(func_t f);
    cnt_t n;
    unique case (f)
      FN_NEC, FN_NECEXT, FN_SAMSUNG: n = 7'd67;
      FN_SONY12:                     n = 7'd26;
      FN_SONY15:                     n = 7'd32;
      FN_SONY20:                     n = 7'd42;
      FN_JVC:                        n = 7'd35;
      default:                       n = 7'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- sv/ire_ifs.sv -----
// ----------------------------------------------------------------------------
// ire_ifs
// Valid/ready channel interfaces: request input, result output and the
// capacity register write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface ire_in_if import ire_pkg::*; ();
  logic  valid;
  logic  ready;
  func_t func;
  addr_t device_address;
  cmd_t  key_command;

  modport source (output valid, output func, output device_address, output key_command,
                  input ready);
  modport sink   (input valid, input func, input device_address, input key_command,
                  output ready);
endinterface

interface ire_out_if import ire_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  us_t     mark_us;
  us_t     space_us;
  us_t     carrier_freq;
  cnt_t    duration_count;
  logic    last;

  modport source (output valid, output status, output mark_us, output space_us,
                  output carrier_freq, output duration_count, output last, input ready);
  modport sink   (input valid, input status, input mark_us, input space_us,
                  input carrier_freq, input duration_count, input last, output ready);
endinterface

interface ire_cfg_if import ire_pkg::*; ();
  logic valid;
  logic ready;
  cap_t buffer_capacity;

  modport source (output valid, output buffer_capacity, input ready);
  modport sink   (input valid, input buffer_capacity, output ready);
endinterface

`default_nettype wire

// ----- sv/ir_remote_frame_encoder_core.sv -----
// ----------------------------------------------------------------------------
// ir_remote_frame_encoder_core
// Turns one request (protocol, address, command) into the IR frame as a
// sequence of mark/space pairs with carrier frequency and status.
//
//   channel  | dir | payload                                      | transfer
//   in_if    | in  | func, device_address, key_command            | valid & ready
//   out_if   | out | status, mark_us, space_us, carrier_freq,
//            |     | duration_count, last                         | valid & ready
//   cfg_if   | in  | buffer_capacity                              | valid & ready
//
// Each pair is built in a mark state and a space state, and a new request
// is taken only once the frame's last result is pushed; RC5 first adds a
// run-count pass over its Manchester runs (at most 27 runs). Raw, unknown
// and zero-capacity requests give a single status result, as does a
// capacity overflow, found after the RC5 pass. Reset is synchronous; capacity
// resets to 128. A stalled output holds the next pair and freezes the generator.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_remote_frame_encoder_core import ire_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  ire_in_if.sink      in_if,
  ire_out_if.source   out_if,
  ire_cfg_if.sink     cfg_if
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_COUNT  = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_MARK   = 3'd4;
  localparam logic [2:0] S_SPACE  = 3'd5;
  localparam logic [2:0] S_SINGLE = 3'd6;

  logic [2:0] st_r, st_nxt;
  req_t       req_r, req_nxt;
  cnt_t       ndur_r, ndur_nxt;
  cnt_t       take_r, take_nxt;
  us_t        mark_r, mark_nxt;
  status_t    sts_r, sts_nxt;
  cap_t       cap_r;

  gen_ctl_t   gen_ctl;
  gen_sts_t   gen_sts;
  logic       push;
  logic       can_push;
  result_t    res;
  us_t        carrier;
  logic       at_end;
  logic       is_last;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_if.valid) begin
      cap_r <= cfg_if.buffer_capacity;
    end
  end

  assign in_if.ready = (st_r == S_IDLE);
  assign carrier     = carrier_of(req_r.func);
  assign at_end      = (take_r == ndur_r);
  assign is_last     = at_end || ((take_r + 7'd1) == ndur_r);

  ire_durgen u_durgen (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (gen_ctl),
    .req   (req_r),
    .sts   (gen_sts)
  );

  ire_outreg u_outreg (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .data     (res),
    .can_push (can_push),
    .out_if   (out_if)
  );

  always_comb begin
    st_nxt   = st_r;
    req_nxt  = req_r;
    ndur_nxt = ndur_r;
    take_nxt = take_r;
    mark_nxt = mark_r;
    sts_nxt  = sts_r;
    gen_ctl  = '0;
    push     = 1'b0;
    res      = '{ST_OK, 16'd0, 16'd0, carrier, 7'd0, 1'b1};

    unique case (st_r)
      S_IDLE: begin
        if (in_if.valid) begin
          req_nxt = '{in_if.func, in_if.device_address, in_if.key_command};
          st_nxt  = S_LOAD;
        end
      end
      S_LOAD: begin
        priority if (cap_r == 11'd0) begin
          sts_nxt = ST_OVERFLOW;
          st_nxt  = S_SINGLE;
        end else if (req_r.func == FN_RAW) begin
          sts_nxt = ST_OK;
          st_nxt  = S_SINGLE;
        end else if (req_r.func > FN_JVC) begin
          sts_nxt = ST_UNKNOWN;
          st_nxt  = S_SINGLE;
        end else begin
          gen_ctl.load = 1'b1;
          ndur_nxt     = ndur_of(req_r.func);
          st_nxt       = (req_r.func == FN_RC5) ? S_COUNT : S_CHECK;
        end
      end
      S_COUNT: begin
        // dry run over the Manchester runs to learn the frame length
        if (gen_sts.empty) begin
          st_nxt = S_CHECK;
        end else begin
          gen_ctl.step = 1'b1;
          ndur_nxt     = ndur_r + 7'd1;
        end
      end
      S_CHECK: begin
        gen_ctl.load = 1'b1;
        take_nxt     = 7'd0;
        if ({4'd0, ndur_r} > cap_r) begin
          sts_nxt = ST_OVERFLOW;
          st_nxt  = S_SINGLE;
        end else begin
          // drop a trailing space
          ndur_nxt = ndur_r[0] ? ndur_r : (ndur_r - 7'd1);
          st_nxt   = S_MARK;
        end
      end
      S_MARK: begin
        mark_nxt     = gen_sts.dur;
        gen_ctl.step = 1'b1;
        take_nxt     = take_r + 7'd1;
        st_nxt       = S_SPACE;
      end
      S_SPACE: begin
        res = '{ST_OK, mark_r, (at_end ? 16'd0 : gen_sts.dur), carrier,
                (is_last ? ndur_r : 7'd0), is_last};
        if (can_push) begin
          push = 1'b1;
          if (!at_end) begin
            gen_ctl.step = 1'b1;
            take_nxt     = take_r + 7'd1;
          end
          st_nxt = is_last ? S_IDLE : S_MARK;
        end
      end
      S_SINGLE: begin
        res = '{sts_r, 16'd0, 16'd0, carrier, 7'd0, 1'b1};
        if (can_push) begin
          push   = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ndur_r <= 7'd0;
      take_r <= 7'd0;
      sts_r  <= ST_OK;
    end else begin
      st_r   <= st_nxt;
      ndur_r <= ndur_nxt;
      take_r <= take_nxt;
      sts_r  <= sts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    mark_r <= mark_nxt;
  end

endmodule

`default_nettype wire

// ----- sv/ire_durgen.sv -----
// ----------------------------------------------------------------------------
// ire_durgen
// Serial duration generator: walks the frame one duration per step, shifting
// the payload out one bit (or one Manchester run) at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module ire_durgen import ire_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  gen_ctl_t ctl,
  input  req_t     req,
  output gen_sts_t sts
);

  localparam logic [2:0] PH_HMARK  = 3'd0;
  localparam logic [2:0] PH_HSPACE = 3'd1;
  localparam logic [2:0] PH_BMARK  = 3'd2;
  localparam logic [2:0] PH_BSPACE = 3'd3;
  localparam logic [2:0] PH_TAIL   = 3'd4;
  localparam logic [2:0] PH_END    = 3'd5;

  func_t       func_r, func_nxt;
  logic [2:0]  ph_r, ph_nxt;
  logic [31:0] sr_r, sr_nxt;
  logic [5:0]  bc_r, bc_nxt;
  logic [27:0] lv_r, lv_nxt;
  logic [4:0]  rl_r, rl_nxt;

  logic [31:0] sr_ld;
  logic [5:0]  bc_ld;
  logic [13:0] rc5_frame;
  logic [27:0] rc5_lv;
  timing_t     tm;
  logic        cur_bit;
  logic        rc5_pair;
  us_t         dur;

  // load values
  always_comb begin
    sr_ld = '0;
    bc_ld = 6'd0;
    unique case (req.func)
      FN_NEC: begin
        sr_ld = {~req.cmd, req.cmd, ~req.addr[7:0], req.addr[7:0]};
        bc_ld = 6'd32;
      end
      FN_NECEXT: begin
        sr_ld = {~req.cmd, req.cmd, req.addr[15:8], req.addr[7:0]};
        bc_ld = 6'd32;
      end
      FN_SAMSUNG: begin
        sr_ld = {~req.cmd, req.cmd, req.addr[7:0], req.addr[7:0]};
        bc_ld = 6'd32;
      end
      FN_SONY12, FN_SONY15, FN_SONY20: begin
        sr_ld = {12'd0, req.addr[12:0], req.cmd[6:0]};
        if (req.func == FN_SONY12) begin
          bc_ld = 6'd12;
        end else if (req.func == FN_SONY15) begin
          bc_ld = 6'd15;
        end else begin
          bc_ld = 6'd20;
        end
      end
      FN_JVC: begin
        sr_ld = {16'd0, req.cmd, req.addr[7:0]};
        bc_ld = 6'd16;
      end
      default: begin
        sr_ld = '0;
        bc_ld = 6'd0;
      end
    endcase
  end

  // RC5: start bit, S2 = 1, toggle = 0, 5 address bits, 6 command bits
  assign rc5_frame = {2'b11, 1'b0, req.addr[4:0], req.cmd[5:0]};

  always_comb begin
    for (int b = 0; b < 14; b++) begin
      rc5_lv[2*b+1] = ~rc5_frame[b];
      rc5_lv[2*b]   = rc5_frame[b];
    end
  end

  // current duration
  assign tm       = timing_of(func_r);
  assign cur_bit  = sr_r[0];
  assign rc5_pair = (rl_r >= 5'd2) && (lv_r[27] == lv_r[26]);

  always_comb begin
    if (func_r == FN_RC5) begin
      dur = rc5_pair ? RC5_LONG : RC5_SHORT;
    end else begin
      unique case (ph_r)
        PH_HMARK:  dur = tm.hdr_mark;
        PH_HSPACE: dur = tm.hdr_space;
        PH_BMARK:  dur = cur_bit ? tm.mark1 : tm.mark0;
        PH_BSPACE: dur = cur_bit ? tm.space1 : tm.space0;
        PH_TAIL:   dur = tm.mark0;
        default:   dur = '0;
      endcase
    end
  end

  assign sts.dur   = dur;
  assign sts.empty = (func_r == FN_RC5) ? (rl_r == 5'd0) : (ph_r == PH_END);

  always_comb begin
    func_nxt = func_r;
    ph_nxt   = ph_r;
    sr_nxt   = sr_r;
    bc_nxt   = bc_r;
    lv_nxt   = lv_r;
    rl_nxt   = rl_r;
    if (ctl.load) begin
      func_nxt = req.func;
      ph_nxt   = PH_HMARK;
      sr_nxt   = sr_ld;
      bc_nxt   = bc_ld;
      // drop the leading space level
      lv_nxt   = {rc5_lv[26:0], 1'b0};
      rl_nxt   = 5'd27;
    end else if (ctl.step) begin
      if (func_r == FN_RC5) begin
        if (rc5_pair) begin
          lv_nxt = {lv_r[25:0], 2'b00};
          rl_nxt = rl_r - 5'd2;
        end else if (rl_r != 5'd0) begin
          lv_nxt = {lv_r[26:0], 1'b0};
          rl_nxt = rl_r - 5'd1;
        end
      end else begin
        unique case (ph_r)
          PH_HMARK:  ph_nxt = PH_HSPACE;
          PH_HSPACE: ph_nxt = PH_BMARK;
          PH_BMARK:  ph_nxt = PH_BSPACE;
          PH_BSPACE: begin
            sr_nxt = {1'b0, sr_r[31:1]};
            bc_nxt = bc_r - 6'd1;
            if (bc_r == 6'd1) begin
              ph_nxt = is_sony(func_r) ? PH_END : PH_TAIL;
            end else begin
              ph_nxt = PH_BMARK;
            end
          end
          PH_TAIL:   ph_nxt = PH_END;
          default:   ph_nxt = PH_END;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_r <= FN_RAW;
      ph_r   <= PH_END;
      sr_r   <= '0;
      bc_r   <= 6'd0;
      lv_r   <= '0;
      rl_r   <= 5'd0;
    end else begin
      func_r <= func_nxt;
      ph_r   <= ph_nxt;
      sr_r   <= sr_nxt;
      bc_r   <= bc_nxt;
      lv_r   <= lv_nxt;
      rl_r   <= rl_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ire_outreg.sv -----
// ----------------------------------------------------------------------------
// ire_outreg
// Result output register: holds one mark/space pair until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ire_outreg import ire_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  result_t       data,
  output logic          can_push,
  ire_out_if.source     out_if
);

  logic    valid_r;
  result_t data_r;

  assign can_push = !valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_if.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= data;
    end
  end

  assign out_if.valid          = valid_r;
  assign out_if.status         = data_r.status;
  assign out_if.mark_us        = data_r.mark_us;
  assign out_if.space_us       = data_r.space_us;
  assign out_if.carrier_freq   = data_r.carrier_freq;
  assign out_if.duration_count = data_r.duration_count;
  assign out_if.last           = data_r.last;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IR remote frame encoder core. Requests go in
// over the request channel in random bursts while the result channel stalls
// on a rotating pattern. Every accepted request is run through a local
// frame builder, and each result transfer is checked field by field against
// the oldest pending pair. The capacity register is moved between phases,
// zero, one and the all-ones value among them.
// ----------------------------------------------------------------------------
module tb import ire_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int PHASE_ITEMS    = 62;

  logic clk;
  logic rst_n;

  ire_in_if  in_if();
  ire_out_if out_if();
  ire_cfg_if cfg_if();

  ir_remote_frame_encoder_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // expected result pairs, oldest first
  result_t pending_pairs[$];
  // durations of the frame being built
  us_t     frame_us[$];
  cap_t    capacity_model;
  int      err_count = 0;
  int      pair_index = 0;
  int      burst_left = 0;
  int      idle_cycles = 0;
  result_t want;

  logic [15:0] rx_pat = 16'hFFFF;
  logic [3:0]  rx_pos = 4'd0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void put_pulse_byte(logic [7:0] v, us_t mk, us_t sp0, us_t sp1);
    for (int i = 0; i < 8; i++) begin
      frame_us.push_back(mk);
      frame_us.push_back(v[i] ? sp1 : sp0);
    end
  endfunction

  // Sony: bit value sets the mark width, LSB first
  function automatic void put_sony_bits(logic [12:0] v, int nbits);
    for (int i = 0; i < nbits; i++) begin
      frame_us.push_back(v[i] ? 16'd1200 : 16'd600);
      frame_us.push_back(16'd600);
    end
  endfunction

  // RC5: Manchester levels, merge equal neighbors into runs, skip the idle lead
  function automatic void put_rc5(addr_t a, cmd_t c);
    logic [13:0] word;
    logic [27:0] lv;
    int i;
    int j;
    word = {1'b1, 1'b1, 1'b0, a[4:0], c[5:0]};
    lv = '0;
    for (int b = 13; b >= 0; b--) begin
      lv = {lv[25:0], word[b] ? 2'b01 : 2'b10};
    end
    i = 0;
    while (i < 28 && !lv[27 - i]) i++;
    while (i < 28) begin
      j = i;
      while (j < 28 && lv[27 - j] == lv[27 - i]) j++;
      frame_us.push_back(us_t'((j - i) * 889));
      i = j;
    end
  endfunction

  function automatic void predict_frame(func_t f, addr_t a, cmd_t c);
    result_t r;
    int      n;
    int      npairs;
    r = '0;
    r.last = 1'b1;
    if (f == FN_SONY12 || f == FN_SONY15 || f == FN_SONY20) begin
      r.carrier_freq = 16'd40000;
    end else if (f == FN_RC5) begin
      r.carrier_freq = 16'd36000;
    end else begin
      r.carrier_freq = 16'd38000;
    end
    frame_us.delete();
    case (f)
      FN_NEC, FN_NECEXT, FN_SAMSUNG: begin
        frame_us.push_back(f == FN_SAMSUNG ? 16'd4500 : 16'd9000);
        frame_us.push_back(16'd4500);
        put_pulse_byte(a[7:0], 16'd560, 16'd560, 16'd1690);
        if (f == FN_NEC) begin
          put_pulse_byte(~a[7:0], 16'd560, 16'd560, 16'd1690);
        end else if (f == FN_NECEXT) begin
          put_pulse_byte(a[15:8], 16'd560, 16'd560, 16'd1690);
        end else begin
          put_pulse_byte(a[7:0], 16'd560, 16'd560, 16'd1690);
        end
        put_pulse_byte(c, 16'd560, 16'd560, 16'd1690);
        put_pulse_byte(~c, 16'd560, 16'd560, 16'd1690);
        frame_us.push_back(16'd560);
      end
      FN_SONY12, FN_SONY15, FN_SONY20: begin
        frame_us.push_back(16'd2400);
        frame_us.push_back(16'd600);
        put_sony_bits({6'd0, c[6:0]}, 7);
        put_sony_bits(a[12:0], (f == FN_SONY12) ? 5 : ((f == FN_SONY15) ? 8 : 13));
      end
      FN_RC5: put_rc5(a, c);
      FN_JVC: begin
        frame_us.push_back(16'd8400);
        frame_us.push_back(16'd4200);
        put_pulse_byte(a[7:0], 16'd525, 16'd525, 16'd1575);
        put_pulse_byte(c, 16'd525, 16'd525, 16'd1575);
        frame_us.push_back(16'd525);
      end
      default: ;
    endcase
    n = frame_us.size();
    if (capacity_model == '0) begin
      r.status = ST_OVERFLOW;
      pending_pairs.push_back(r);
    end else if (f == FN_RAW) begin
      r.status = ST_OK;
      pending_pairs.push_back(r);
    end else if (f > FN_JVC) begin
      r.status = ST_UNKNOWN;
      pending_pairs.push_back(r);
    end else if (n > int'(capacity_model)) begin
      r.status = ST_OVERFLOW;
      pending_pairs.push_back(r);
    end else begin
      // drop a trailing space so the frame ends on a mark
      if (n % 2 == 0) n--;
      npairs = (n + 1) / 2;
      for (int k = 0; k < npairs; k++) begin
        r.status = ST_OK;
        r.mark_us = frame_us[2 * k];
        r.space_us = (2 * k + 1 < n) ? frame_us[2 * k + 1] : 16'd0;
        r.last = (k + 1 == npairs);
        r.duration_count = r.last ? cnt_t'(n) : '0;
        pending_pairs.push_back(r);
      end
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_err(string what);
    err_count++;
    if (err_count <= 40) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] exp_val);
    if (got !== exp_val)
      report_err($sformatf("pair %0d %s: got %0d, want %0d", pair_index, name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_pairs.size() == 0) begin
        report_err($sformatf("pair %0d arrived with nothing pending (mark %0d)",
                             pair_index, out_if.mark_us));
      end else begin
        want = pending_pairs.pop_front();
        check_field("status", 16'(out_if.status), 16'(want.status));
        check_field("mark_us", out_if.mark_us, want.mark_us);
        check_field("space_us", out_if.space_us, want.space_us);
        check_field("carrier_freq", out_if.carrier_freq, want.carrier_freq);
        check_field("duration_count", 16'(out_if.duration_count), 16'(want.duration_count));
        check_field("last", 16'(out_if.last), 16'(want.last));
      end
      pair_index++;
    end
  end

  // result side: rotate a 16-bit ready pattern, often all ones
  always @(posedge clk) begin
    out_if.ready <= rx_pat[rx_pos];
    rx_pos <= rx_pos + 4'd1;
    if (rx_pos == 4'd15) begin
      rx_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end
  end

  // end the run if no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("** ir_remote_frame_encoder_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // sender bursts: hold valid through a burst, drop it for a random gap
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_if.valid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8))
        @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic send_request(func_t f, addr_t a, cmd_t c);
    in_if.valid <= 1'b1;
    in_if.func <= f;
    in_if.device_address <= a;
    in_if.key_command <= c;
    do @(posedge clk); while (!in_if.ready);
    predict_frame(f, a, c);
    pace();
  endtask

  // drop valid, then wait on the clock until no pair is pending
  task automatic wait_frames_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_pairs.size() != 0);
  endtask

  task automatic write_capacity(cap_t v);
    wait_frames_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.buffer_capacity <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    capacity_model = v;
  endtask

  task automatic test_directed_frames();
    send_request(FN_NEC, 16'h0000, 8'h00);
    send_request(FN_NEC, 16'hFFFF, 8'hFF);
    send_request(FN_NECEXT, 16'h12A5, 8'h3C);
    send_request(FN_NECEXT, 16'hFFFF, 8'h00);
    send_request(FN_SAMSUNG, 16'h00FF, 8'hAA);
    send_request(FN_SONY12, 16'h001F, 8'h7F);
    send_request(FN_SONY15, 16'h00FF, 8'h00);
    send_request(FN_SONY20, 16'h1FFF, 8'h55);
    send_request(FN_RC5, 16'h0000, 8'h00);
    send_request(FN_RC5, 16'hFFFF, 8'hFF);
    send_request(FN_JVC, 16'h0000, 8'hFF);
    send_request(FN_JVC, 16'hFFFF, 8'h00);
    send_request(FN_RAW, 16'hFFFF, 8'hFF);
    send_request(func_t'(4'd9), 16'h1234, 8'h56);
    send_request(func_t'(4'd15), 16'hFFFF, 8'hFF);
  endtask

  task automatic test_capacity_edges();
    // zero capacity rejects everything, raw and unknown included
    write_capacity(11'd0);
    send_request(FN_RAW, 16'h0000, 8'h00);
    send_request(FN_NEC, 16'h00A5, 8'h5A);
    send_request(func_t'(4'd9), 16'h0000, 8'h00);
    // NEC needs 67 durations
    write_capacity(11'd66);
    send_request(FN_NEC, 16'h0F0F, 8'hC3);
    write_capacity(11'd67);
    send_request(FN_SAMSUNG, 16'h0077, 8'h18);
    // Sony counts the trailing space before it is dropped
    write_capacity(11'd25);
    send_request(FN_SONY12, 16'h0015, 8'h2A);
    write_capacity(11'd26);
    send_request(FN_SONY12, 16'h000A, 8'h55);
    write_capacity(11'd1);
    send_request(FN_JVC, 16'h00C3, 8'h3C);
    send_request(FN_RAW, 16'h0000, 8'h00);
    write_capacity(11'h7FF);
    send_request(FN_NECEXT, 16'hBEEF, 8'h81);
  endtask

  task automatic test_random_traffic();
    cap_t  caps[7];
    int    r;
    func_t f;
    addr_t a;
    cmd_t  c;
    caps[0] = 11'd1024;
    caps[1] = cap_t'($urandom_range(24, 70));
    caps[2] = 11'h7FF;
    caps[3] = cap_t'($urandom_range(1, 1024));
    caps[4] = 11'd67;
    caps[5] = cap_t'($urandom_range(26, 45));
    caps[6] = CAP_RESET;
    for (int p = 0; p < 7; p++) begin
      write_capacity(caps[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 19);
        if (r < 2) begin
          f = FN_RAW;
        end else if (r < 4) begin
          f = func_t'($urandom_range(9, 15));
        end else begin
          f = func_t'($urandom_range(1, 8));
        end
        a = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                          : addr_t'($urandom);
        c = cmd_t'($urandom);
        send_request(f, a, c);
        // now and then hold off until the result side is empty
        if ($urandom_range(0, 39) == 0) wait_frames_drained();
      end
    end
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.func <= FN_RAW;
    in_if.device_address <= '0;
    in_if.key_command <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.buffer_capacity <= CAP_RESET;
    capacity_model = CAP_RESET;
    do @(posedge clk); while (!rst_n);

    test_directed_frames();
    test_capacity_edges();
    test_random_traffic();

    wait_frames_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_pairs.size() != 0)
      report_err($sformatf("%0d pairs never arrived", pending_pairs.size()));

    if (err_count == 0) begin
      $display("** ir_remote_frame_encoder_core: PASSED **");
    end else begin
      $display("** ir_remote_frame_encoder_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- ir_remote_frame_encoder_core.f -----
sv/ire_pkg.sv
sv/ire_ifs.sv
sv/ire_durgen.sv
sv/ire_outreg.sv
sv/ir_remote_frame_encoder_core.sv
sim/tb.sv
